// ----- hdl/dtq_pkg.sv -----
`default_nettype none
package dtq_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [29:0] NSEC_PER_SEC   = 30'd1000000000;
  localparam logic [29:0] NSEC_MAX       = 30'd999999999;
  localparam logic [29:0] TICK_INC_RESET = 30'd10000000;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_ARM_AT    = 3'd1,
    CMD_ARM_AFTER = 3'd2,
    CMD_DISARM    = 3'd3,
    CMD_SET_RT    = 3'd4,
    CMD_READ      = 3'd5
  } cmd_t;

  localparam logic [1:0] KIND_EXPIRED  = 2'd0;
  localparam logic [1:0] KIND_DISARMED = 2'd1;
  localparam logic [1:0] KIND_CLOCK    = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  localparam logic [1:0] SLOT_DISARMED = 2'd0;
  localparam logic [1:0] SLOT_ARMED    = 2'd1;
  localparam logic [1:0] SLOT_EXPIRED  = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  timer_id;
    logic        clock_sel;
    logic [31:0] time_sec;
    logic [29:0] time_nsec;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  timer_id_out;
    logic [31:0] clock_sec;
    logic [29:0] clock_nsec;
    logic [31:0] tick_count;
    logic        last;
  } out_t;

  // best candidate handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] id;
    logic [31:0]       dsec;
    logic [29:0]       dnsec;
    logic [31:0]       age;
  } carrier_t;

  typedef struct packed {
    logic              en;
    logic              full;
    logic [SLOT_W-1:0] id;
    logic [1:0]        st;
    logic              clk_sel;
    logic [31:0]       dsec;
    logic [29:0]       dnsec;
    logic [31:0]       order;
  } slot_wr_t;

  // nanosecond add with carry out in the top bit
  function automatic logic [30:0] add_ns(input logic [29:0] a, input logic [29:0] b);
    logic [30:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, NSEC_PER_SEC}) begin
      add_ns = {1'b1, 30'(sum - {1'b0, NSEC_PER_SEC})};
    end else begin
      add_ns = {1'b0, sum[29:0]};
    end
  endfunction

  function automatic logic earlier_than(input logic [31:0] as, input logic [29:0] an,
                                        input logic [31:0] bs, input logic [29:0] bn);
    earlier_than = (as < bs) || ((as == bs) && (an < bn));
  endfunction

endpackage
`default_nettype wire

// ----- hdl/deadline_timer_queue.sv -----
// Channel  Dir  Handshake             Payload
// req      in   req_valid/req_stall   dtq_pkg::in_t
// rsp      out  rsp_valid/rsp_stall   dtq_pkg::out_t
// cfg      in   cfg_we                cfg_data (tick increment, ns)
// One command at a time. Arm steps through ST_ARM_ADD and ST_ARM_WRITE;
// disarm, read and errors go straight to ST_FLUSH. Each expiry search
// sweeps the cell row; a tick searches the realtime clock, then the
// monotonic one, and each expiry found starts a new sweep.
// Synchronous reset clears clocks, tick count and all slots to disarmed.
// A stalled rsp holds the search until its single output register frees.
`default_nettype none
module deadline_timer_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  dtq_pkg::in_t   req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output dtq_pkg::out_t  rsp,
  input  logic           cfg_we,
  input  logic [29:0]    cfg_data
);
  import dtq_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_ARM_ADD   = 6'b000010,
    ST_ARM_WRITE = 6'b000100,
    ST_SCAN      = 6'b001000,
    ST_DECIDE    = 6'b010000,
    ST_FLUSH     = 6'b100000
  } state_t;

  state_t            state;
  in_t               req_q;
  logic [31:0]       rt_sec, mono_sec, ticks, arm_cnt;
  logic [29:0]       rt_nsec, mono_nsec, inc_cfg;
  logic              cur_clk;
  logic [SLOT_W-1:0] scan_cnt;
  logic [RES_W-1:0]  res_cnt;
  logic              pend_valid;
  out_t              pend;
  logic [31:0]       arm_dsec;
  logic [29:0]       arm_dnsec;

  logic [29:0]       inc_eff;
  logic [30:0]       rt_adv, mono_adv, arm_ns;
  logic              accept, out_free, slot_ok, live_ok, nsec_bad;
  logic [31:0]       scan_sec, q_sec;
  logic [29:0]       scan_nsec, q_nsec;
  logic              arm_due, decide_due, decide_go, rsp_load;
  slot_wr_t          wr;
  carrier_t          chain [TIMER_SLOTS+1];
  logic [TIMER_SLOTS-1:0] armed_vec;
  carrier_t          best;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  assign inc_eff   = (inc_cfg >= NSEC_PER_SEC) ? NSEC_MAX : inc_cfg;
  assign rt_adv    = add_ns(rt_nsec, inc_eff);
  assign mono_adv  = add_ns(mono_nsec, inc_eff);

  assign live_ok   = ({28'd0, req.timer_id} < 32'(TIMER_SLOTS));
  assign nsec_bad  = (req.time_nsec >= NSEC_PER_SEC);
  assign slot_ok   = live_ok && !armed_vec[SLOT_W'(req.timer_id)];

  assign q_sec     = req_q.clock_sel ? mono_sec : rt_sec;
  assign q_nsec    = req_q.clock_sel ? mono_nsec : rt_nsec;
  assign arm_ns    = add_ns(q_nsec, req_q.time_nsec);
  assign arm_due   = !earlier_than(q_sec, q_nsec, arm_dsec, arm_dnsec);

  assign scan_sec  = cur_clk ? mono_sec : rt_sec;
  assign scan_nsec = cur_clk ? mono_nsec : rt_nsec;
  assign best      = chain[TIMER_SLOTS];
  assign decide_due = best.valid && !earlier_than(scan_sec, scan_nsec, best.dsec, best.dnsec);
  assign decide_go = (state == ST_DECIDE) && decide_due && (!pend_valid || out_free);
  assign rsp_load  = (decide_go && pend_valid) ||
                     ((state == ST_FLUSH) && pend_valid && out_free);

  always_comb begin
    wr         = '0;
    wr.dsec    = arm_dsec;
    wr.dnsec   = arm_dnsec;
    wr.clk_sel = req_q.clock_sel;
    wr.order   = arm_cnt;
    wr.id      = SLOT_W'(req_q.timer_id);
    if (accept && (req.cmd == CMD_DISARM) && live_ok) begin
      wr.en = 1'b1;
      wr.id = SLOT_W'(req.timer_id);
      wr.st = SLOT_DISARMED;
    end else if (state == ST_ARM_WRITE) begin
      wr.en   = 1'b1;
      wr.full = 1'b1;
      wr.st   = arm_due ? SLOT_EXPIRED : SLOT_ARMED;
    end else if (decide_go) begin
      wr.en = 1'b1;
      wr.id = best.id;
      wr.st = SLOT_EXPIRED;
    end
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    dtq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .slot_id   (SLOT_W'(i)),
      .wr        (wr),
      .scan_clk  (cur_clk),
      .arm_count (arm_cnt),
      .carry_in  (chain[i]),
      .carry_out (chain[i+1]),
      .armed     (armed_vec[i])
    );
  end

  function automatic out_t mk_res(input logic [1:0] kind, input logic [3:0] id,
                                  input logic [31:0] sec, input logic [29:0] nsec,
                                  input logic [31:0] tc);
    out_t r;
    r.kind         = kind;
    r.timer_id_out = id;
    r.clock_sec    = sec;
    r.clock_nsec   = nsec;
    r.tick_count   = tc;
    r.last         = 1'b0;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rt_sec     <= '0;
      rt_nsec    <= '0;
      mono_sec   <= '0;
      mono_nsec  <= '0;
      ticks      <= '0;
      arm_cnt    <= '0;
      inc_cfg    <= TICK_INC_RESET;
      cur_clk    <= 1'b0;
      scan_cnt   <= '0;
      res_cnt    <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        inc_cfg <= cfg_data;
      end
      if (rsp_valid && !rsp_stall && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            req_q      <= req;
            res_cnt    <= '0;
            pend_valid <= 1'b0;
            cur_clk    <= 1'b0;
            scan_cnt   <= '0;
            state      <= ST_FLUSH;
            case (req.cmd)
              CMD_TICK: begin
                ticks     <= ticks + 32'd1;
                rt_nsec   <= rt_adv[29:0];
                rt_sec    <= rt_sec + {31'd0, rt_adv[30]};
                mono_nsec <= mono_adv[29:0];
                mono_sec  <= mono_sec + {31'd0, mono_adv[30]};
                state     <= ST_SCAN;
              end
              CMD_ARM_AT, CMD_ARM_AFTER: begin
                if (!slot_ok || nsec_bad) begin
                  pend       <= mk_res(KIND_ERROR, '0, '0, '0, '0);
                  pend_valid <= 1'b1;
                end else begin
                  state <= ST_ARM_ADD;
                end
              end
              CMD_DISARM: begin
                pend_valid <= 1'b1;
                pend <= live_ok ? mk_res(KIND_DISARMED, req.timer_id, '0, '0, '0)
                                : mk_res(KIND_ERROR, '0, '0, '0, '0);
              end
              CMD_SET_RT: begin
                if (nsec_bad || req.clock_sel) begin
                  pend       <= mk_res(KIND_ERROR, '0, '0, '0, '0);
                  pend_valid <= 1'b1;
                end else begin
                  rt_sec  <= req.time_sec;
                  rt_nsec <= req.time_nsec;
                  state   <= ST_SCAN;
                end
              end
              CMD_READ: begin
                pend_valid <= 1'b1;
                pend <= req.clock_sel ? mk_res(KIND_CLOCK, '0, mono_sec, mono_nsec, ticks)
                                      : mk_res(KIND_CLOCK, '0, rt_sec, rt_nsec, ticks);
              end
              default: begin
                pend       <= mk_res(KIND_ERROR, '0, '0, '0, '0);
                pend_valid <= 1'b1;
              end
            endcase
          end
        end
        ST_ARM_ADD: begin
          if (req_q.cmd == CMD_ARM_AFTER) begin
            arm_dsec  <= q_sec + req_q.time_sec + {31'd0, arm_ns[30]};
            arm_dnsec <= arm_ns[29:0];
          end else begin
            arm_dsec  <= req_q.time_sec;
            arm_dnsec <= req_q.time_nsec;
          end
          state <= ST_ARM_WRITE;
        end
        ST_ARM_WRITE: begin
          arm_cnt <= arm_cnt + 32'd1;
          if (arm_due) begin
            pend       <= mk_res(KIND_EXPIRED, req_q.timer_id, '0, '0, '0);
            pend_valid <= 1'b1;
            state      <= ST_FLUSH;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == SLOT_W'(TIMER_SLOTS - 1)) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (!decide_due) begin
            if ((req_q.cmd == CMD_TICK) && !cur_clk) begin
              cur_clk  <= 1'b1;
              scan_cnt <= '0;
              state    <= ST_SCAN;
            end else begin
              state <= ST_FLUSH;
            end
          end else if (decide_go) begin
            // pass the held beat on; the new expiry becomes the held one
            if (pend_valid) begin
              rsp       <= pend;
              rsp_valid <= 1'b1;
            end
            pend       <= mk_res(KIND_EXPIRED, 4'(best.id), '0, '0, '0);
            pend_valid <= 1'b1;
            res_cnt    <= res_cnt + 1'b1;
            scan_cnt   <= '0;
            if (res_cnt == RES_W'(MAX_RESULTS - 1)) begin
              state <= ST_FLUSH;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            rsp        <= out_t'({pend[$bits(out_t)-1:1], 1'b1});
            rsp_valid  <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_best_armed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && best.valid) |-> armed_vec[best.id])
    else $error("search result names a slot that is not armed");

  a_res_cap: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= RES_W'(MAX_RESULTS))
    else $error("too many results for one command");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_valid)
    else $error("held beat left over when idle");

  a_expire_marks: assert property (@(posedge clk) disable iff (rst)
    decide_go |=> !armed_vec[$past(best.id)])
    else $error("expired slot still armed");
`endif

endmodule
`default_nettype wire

// ----- hdl/dtq_cell.sv -----
`default_nettype none
module dtq_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [dtq_pkg::SLOT_W-1:0] slot_id,
  input  dtq_pkg::slot_wr_t         wr,
  input  logic                      scan_clk,
  input  logic [31:0]               arm_count,
  input  dtq_pkg::carrier_t         carry_in,
  output dtq_pkg::carrier_t         carry_out,
  output logic                      armed
);
  import dtq_pkg::*;

  logic [1:0]  st;
  logic        sclk;
  logic [31:0] dsec;
  logic [29:0] dnsec;
  logic [31:0] order;
  logic [31:0] age;
  logic        mine;
  logic        take;
  logic        hit;

  assign hit   = wr.en && (wr.id == slot_id);
  assign age   = arm_count - order;
  assign mine  = (st == SLOT_ARMED) && (sclk == scan_clk);
  assign armed = (st == SLOT_ARMED);

  // earlier deadline wins; on a tie the older arm wins
  assign take = mine && (!carry_in.valid || (dsec < carry_in.dsec) ||
                ((dsec == carry_in.dsec) && ((dnsec < carry_in.dnsec) ||
                ((dnsec == carry_in.dnsec) && (age > carry_in.age)))));

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SLOT_DISARMED;
    end else if (hit) begin
      st <= wr.st;
    end
  end

  always_ff @(posedge clk) begin
    if (hit && wr.full) begin
      sclk  <= wr.clk_sel;
      dsec  <= wr.dsec;
      dnsec <= wr.dnsec;
      order <= wr.order;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out.valid <= 1'b0;
    end else begin
      carry_out.valid <= take || carry_in.valid;
    end
    if (take) begin
      carry_out.id    <= slot_id;
      carry_out.dsec  <= dsec;
      carry_out.dnsec <= dnsec;
      carry_out.age   <= age;
    end else begin
      carry_out.id    <= carry_in.id;
      carry_out.dsec  <= carry_in.dsec;
      carry_out.dnsec <= carry_in.dnsec;
      carry_out.age   <= carry_in.age;
    end
  end

endmodule
`default_nettype wire

// ----- bench/tb_deadline_timer_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_deadline_timer_queue;
  import dtq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] CMD_BAD6 = 3'd6;
  localparam logic [2:0] CMD_BAD7 = 3'd7;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  in_t req;
  logic rsp_valid;
  logic rsp_stall;
  out_t rsp;
  logic cfg_we;
  logic [29:0] cfg_data;

  deadline_timer_queue u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // timer state mirrored on the bench side
  logic [29:0] tick_inc;
  logic [31:0] now_sec [2];
  logic [29:0] now_nsec [2];
  logic [31:0] ticks;
  logic [1:0] tmr_state [TIMER_SLOTS];
  logic tmr_clock [TIMER_SLOTS];
  logic [31:0] tmr_dsec [TIMER_SLOTS];
  logic [29:0] tmr_dnsec [TIMER_SLOTS];
  logic [31:0] tmr_order [TIMER_SLOTS];
  logic [31:0] arm_seq;

  in_t pending_cmds[$];
  out_t expected_rsp[$];
  int errors;
  int cycles;
  bit driving_done;
  bit no_idle;

  function automatic bit earlier(logic [31:0] as, logic [29:0] an,
                                 logic [31:0] bs, logic [29:0] bn);
    return (as < bs) || ((as == bs) && (an < bn));
  endfunction

  function automatic void push_rsp(logic [1:0] k, logic [3:0] id, logic [31:0] s,
                                   logic [29:0] ns, logic [31:0] t);
    out_t r;
    r = '{kind: k, timer_id_out: id, clock_sec: s, clock_nsec: ns,
          tick_count: t, last: 1'b0};
    expected_rsp.push_back(r);
  endfunction

  function automatic int expire_due(int c, int n);
    int best;
    while (n < MAX_RESULTS) begin
      best = -1;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        if (tmr_state[i] != SLOT_ARMED || tmr_clock[i] != c) continue;
        if (best < 0 || earlier(tmr_dsec[i], tmr_dnsec[i], tmr_dsec[best], tmr_dnsec[best])
            || (tmr_dsec[i] == tmr_dsec[best] && tmr_dnsec[i] == tmr_dnsec[best] &&
                32'(arm_seq - tmr_order[i]) > 32'(arm_seq - tmr_order[best])))
          best = i;
      end
      if (best < 0) break;
      if (earlier(now_sec[c], now_nsec[c], tmr_dsec[best], tmr_dnsec[best])) break;
      tmr_state[best] = SLOT_EXPIRED;
      push_rsp(KIND_EXPIRED, 4'(best), '0, '0, '0);
      n++;
    end
    return n;
  endfunction

  function automatic void step_clock(int c, logic [29:0] inc);
    logic [30:0] s;
    s = {1'b0, now_nsec[c]} + {1'b0, inc};
    if (s >= {1'b0, NSEC_PER_SEC}) begin
      s = s - {1'b0, NSEC_PER_SEC};
      now_sec[c] = now_sec[c] + 1;
    end
    now_nsec[c] = s[29:0];
  endfunction

  function automatic void predict_cmd(in_t c);
    int n;
    logic [29:0] inc;
    logic [31:0] ds;
    logic [30:0] dn;
    int cs;
    n = 0;
    cs = c.clock_sel;
    case (c.cmd)
      CMD_TICK: begin
        inc = (tick_inc >= NSEC_PER_SEC) ? NSEC_MAX : tick_inc;
        ticks = ticks + 1;
        step_clock(0, inc);
        n = expire_due(0, n);
        step_clock(1, inc);
        n = expire_due(1, n);
      end
      CMD_ARM_AT, CMD_ARM_AFTER: begin
        if (c.time_nsec >= NSEC_PER_SEC || tmr_state[c.timer_id] == SLOT_ARMED) begin
          push_rsp(KIND_ERROR, '0, '0, '0, '0);
          n = 1;
        end else begin
          ds = c.time_sec;
          dn = {1'b0, c.time_nsec};
          if (c.cmd == CMD_ARM_AFTER) begin
            ds = now_sec[cs] + c.time_sec;
            dn = {1'b0, now_nsec[cs]} + {1'b0, c.time_nsec};
            if (dn >= {1'b0, NSEC_PER_SEC}) begin
              dn = dn - {1'b0, NSEC_PER_SEC};
              ds = ds + 1;
            end
          end
          tmr_state[c.timer_id] = SLOT_ARMED;
          tmr_clock[c.timer_id] = c.clock_sel;
          tmr_dsec[c.timer_id] = ds;
          tmr_dnsec[c.timer_id] = dn[29:0];
          tmr_order[c.timer_id] = arm_seq;
          arm_seq = arm_seq + 1;
          if (!earlier(now_sec[cs], now_nsec[cs], ds, dn[29:0])) begin
            tmr_state[c.timer_id] = SLOT_EXPIRED;
            push_rsp(KIND_EXPIRED, c.timer_id, '0, '0, '0);
            n = 1;
          end
        end
      end
      CMD_DISARM: begin
        tmr_state[c.timer_id] = SLOT_DISARMED;
        tmr_dsec[c.timer_id] = '0;
        tmr_dnsec[c.timer_id] = '0;
        push_rsp(KIND_DISARMED, c.timer_id, '0, '0, '0);
        n = 1;
      end
      CMD_SET_RT: begin
        if (c.time_nsec >= NSEC_PER_SEC || c.clock_sel) begin
          push_rsp(KIND_ERROR, '0, '0, '0, '0);
          n = 1;
        end else begin
          now_sec[0] = c.time_sec;
          now_nsec[0] = c.time_nsec;
          n = expire_due(0, n);
        end
      end
      CMD_READ: begin
        push_rsp(KIND_CLOCK, '0, now_sec[cs], now_nsec[cs], ticks);
        n = 1;
      end
      default: begin
        push_rsp(KIND_ERROR, '0, '0, '0, '0);
        n = 1;
      end
    endcase
    if (n > 0) expected_rsp[expected_rsp.size() - 1].last = 1'b1;
  endfunction

  function automatic in_t mk(logic [2:0] op, logic [3:0] id, logic cs,
                             logic [31:0] s, logic [29:0] ns);
    in_t c;
    c = '{cmd: op, timer_id: id, clock_sel: cs, time_sec: s, time_nsec: ns};
    return c;
  endfunction

  function automatic logic [29:0] rand_nsec();
    case ($urandom_range(0, 5))
      0: return 30'($urandom);
      1: return NSEC_MAX;
      default: return 30'($urandom_range(0, 999999999));
    endcase
  endfunction

  function automatic void add_random(int count);
    logic [31:0] s;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      s = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 1));
      if (r < 35) pending_cmds.push_back(mk(CMD_TICK, 4'($urandom), 1'($urandom), $urandom,
                                            30'($urandom)));
      else if (r < 60) pending_cmds.push_back(mk(CMD_ARM_AFTER, 4'($urandom), 1'($urandom),
                                                 s, rand_nsec()));
      else if (r < 72) pending_cmds.push_back(mk(CMD_ARM_AT, 4'($urandom), 1'($urandom),
                                                 s, rand_nsec()));
      else if (r < 82) pending_cmds.push_back(mk(CMD_DISARM, 4'($urandom), 1'($urandom),
                                                 $urandom, 30'($urandom)));
      else if (r < 88) pending_cmds.push_back(mk(CMD_SET_RT, 4'($urandom),
                                                 1'($urandom_range(0, 4) == 0), s,
                                                 rand_nsec()));
      else if (r < 97) pending_cmds.push_back(mk(CMD_READ, 4'($urandom), 1'($urandom),
                                                 $urandom, 30'($urandom)));
      else pending_cmds.push_back(mk(($urandom & 1) ? CMD_BAD7 : CMD_BAD6, 4'($urandom),
                                     1'($urandom), $urandom, 30'($urandom)));
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: the front of the queue is the beat on the bus until accepted
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (req_valid) begin
        predict_cmd(req);
        void'(pending_cmds.pop_front());
      end
      if (pending_cmds.size() > 0 && !driving_done &&
          (no_idle || $urandom_range(0, 99) >= 19)) begin
        req_valid <= 1'b1;
        req <= pending_cmds[0];
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %p", $time, rsp);
          errors++;
        end else begin
          if (rsp !== expected_rsp[0]) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, expected_rsp[0], rsp);
            errors++;
          end
          void'(expected_rsp.pop_front());
        end
      end
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < 19);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("deadline_timer_queue verification failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_cmds.size() != 0 || req_valid || expected_rsp.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_inc(logic [29:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tick_inc = v;
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    driving_done = 1'b0;
    no_idle = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    tick_inc = TICK_INC_RESET;
    for (int c = 0; c < 2; c++) begin
      now_sec[c] = '0;
      now_nsec[c] = '0;
    end
    ticks = '0;
    arm_seq = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      tmr_state[i] = SLOT_DISARMED;
      tmr_clock[i] = 1'b0;
      tmr_dsec[i] = '0;
      tmr_dnsec[i] = '0;
      tmr_order[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: ties in arm order, both clocks, errors, wraps
    pending_cmds.push_back(mk(CMD_READ, 4'd0, 1'b0, '0, '0));
    pending_cmds.push_back(mk(CMD_ARM_AT, 4'd3, 1'b0, 32'd0, 30'd20000000));
    pending_cmds.push_back(mk(CMD_ARM_AT, 4'd1, 1'b0, 32'd0, 30'd20000000));
    pending_cmds.push_back(mk(CMD_ARM_AFTER, 4'd2, 1'b1, 32'd0, 30'd10000000));
    pending_cmds.push_back(mk(CMD_ARM_AT, 4'd1, 1'b0, 32'd5, 30'd0));
    pending_cmds.push_back(mk(CMD_ARM_AT, 4'd4, 1'b0, 32'd0, NSEC_PER_SEC));
    pending_cmds.push_back(mk(CMD_ARM_AT, 4'd5, 1'b1, 32'd0, 30'h3FFFFFFF));
    pending_cmds.push_back(mk(CMD_ARM_AT, 4'd6, 1'b1, 32'd0, 30'd0));
    pending_cmds.push_back(mk(CMD_TICK, 4'd0, 1'b0, '0, '0));
    pending_cmds.push_back(mk(CMD_TICK, 4'd15, 1'b1, '1, '1));
    pending_cmds.push_back(mk(CMD_ARM_AT, 4'd15, 1'b0, 32'hFFFFFFFF, NSEC_MAX));
    pending_cmds.push_back(mk(CMD_DISARM, 4'd7, 1'b0, '0, '0));
    pending_cmds.push_back(mk(CMD_DISARM, 4'd15, 1'b1, '1, '1));
    pending_cmds.push_back(mk(CMD_SET_RT, 4'd0, 1'b1, 32'd1, 30'd0));
    pending_cmds.push_back(mk(CMD_SET_RT, 4'd0, 1'b0, 32'd1, NSEC_PER_SEC));
    pending_cmds.push_back(mk(CMD_SET_RT, 4'd0, 1'b0, 32'hFFFFFFFF, NSEC_MAX));
    pending_cmds.push_back(mk(CMD_READ, 4'd0, 1'b0, '0, '0));
    pending_cmds.push_back(mk(CMD_ARM_AFTER, 4'd8, 1'b0, 32'd0, NSEC_MAX));
    pending_cmds.push_back(mk(CMD_TICK, 4'd0, 1'b0, '0, '0));
    pending_cmds.push_back(mk(CMD_READ, 4'd0, 1'b1, '0, '0));
    pending_cmds.push_back(mk(CMD_BAD6, 4'd0, 1'b0, '0, '0));
    pending_cmds.push_back(mk(CMD_BAD7, 4'd0, 1'b0, '0, '0));
    drain();

    // many timers due on one tick to hit the per-step result cap
    write_inc(30'h3FFFFFFF);
    for (int i = 0; i < TIMER_SLOTS; i++)
      pending_cmds.push_back(mk(CMD_DISARM, 4'(i), 1'b0, '0, '0));
    for (int i = 0; i < TIMER_SLOTS; i++)
      pending_cmds.push_back(mk(CMD_ARM_AFTER, 4'(i), 1'(i % 2), 32'd0, 30'd500000000));
    pending_cmds.push_back(mk(CMD_TICK, 4'd0, 1'b0, '0, '0));
    drain();

    write_inc(30'd1);
    add_random(20);
    drain();
    no_idle = 1'b1;
    write_inc(30'd999999999);
    add_random(20);
    drain();
    no_idle = 1'b0;
    write_inc(30'($urandom_range(1, 300000000)));
    add_random(15);
    drain();

    if (errors == 0) begin
      $display("deadline_timer_queue verification clean");
    end else begin
      $display("deadline_timer_queue verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/dtq_pkg.sv
hdl/dtq_cell.sv
hdl/deadline_timer_queue.sv
bench/tb_deadline_timer_queue.sv
